/* sv/plen_pkg.sv */
`timescale 1ns / 1ps
// plen_pkg: shared types and constants for the polyline length and area block.
// Depends on nothing; used by plen_mul, plen_isqrt, polyline_length_and_area and tb.

package plen_pkg;

    // Default values of the top-level parameters
    localparam int MAX_POINTS_DEF       = 1024;
    localparam int COORD_BITS_DEF       = 16;
    localparam int LENGTH_FRAC_BITS_DEF = 8;

    // Fixed result widths
    localparam int LEN_W      = 35;
    localparam int AREA_OUT_W = 43;
    localparam int AREA_SUM_W = 44;
    localparam int COUNT_W    = 11;

    // Saturation limits of the running sums
    localparam logic [LEN_W-1:0]      LEN_MAX  = '1;
    localparam logic [AREA_OUT_W-1:0] AREA_MAX = '1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_X,
        S_SQ_Y,
        S_TERM,
        S_START,
        S_WAIT,
        S_NEXT,
        S_DONE
    } state_t;

endpackage

/* sv/plen_mul.sv */
`timescale 1ns / 1ps
// plen_mul: shared signed multiplier with a registered product.
// Takes its default width from plen_pkg; instantiated by polyline_length_and_area.

module plen_mul #(
    parameter int A_W = plen_pkg::COORD_BITS_DEF + 1
) (
    input  logic                    clk,
    input  logic signed [A_W-1:0]   op_a,
    input  logic signed [A_W-1:0]   op_b,
    output logic signed [2*A_W-1:0] prod
);

    logic signed [2*A_W-1:0] prod_reg;

    // Register the product every cycle; the sequencer picks it up in the next cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

/* sv/plen_isqrt.sv */
`timescale 1ns / 1ps
// plen_isqrt: restoring integer square root, one root bit per cycle,
// with extra fraction bits and round-to-nearest. Defaults come from plen_pkg.

module plen_isqrt #(
    parameter int RAD_W     = 2 * plen_pkg::COORD_BITS_DEF + 1,
    parameter int FRAC_BITS = plen_pkg::LENGTH_FRAC_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [RAD_W-1:0]                          radicand,
    output logic                                      done,
    output logic [(RAD_W + 1) / 2 + FRAC_BITS:0]      root_out
);

    localparam int NPAIR = (RAD_W + 1) / 2;
    localparam int SH_W  = 2 * NPAIR;
    localparam int N_IT  = NPAIR + FRAC_BITS;
    localparam int R_W   = N_IT;
    localparam int RM_W  = R_W + 2;
    localparam int CNT_W = (N_IT > 1) ? $clog2(N_IT) : 1;

    logic             busy_reg, busy_next;
    logic             fin_reg, fin_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RM_W-1:0]  rem_reg, rem_next;
    logic [R_W-1:0]   root_reg, root_next;
    logic [SH_W-1:0]  sh_reg, sh_next;
    logic [R_W:0]     root_out_reg, root_out_next;

    logic [RM_W-1:0]  rem_sh;
    logic [RM_W-1:0]  trial;

    // One step: bring down the next bit pair, try to subtract 4*root+1
    always_comb
    begin
        rem_sh = {rem_reg[R_W-1:0], sh_reg[SH_W-1 -: 2]};
        trial  = {root_reg, 2'b01};
    end

    always_comb
    begin
        busy_next     = busy_reg;
        fin_next      = 1'b0;
        done_next     = 1'b0;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        sh_next       = sh_reg;
        root_out_next = root_out_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            root_next = '0;
            sh_next   = SH_W'(radicand);
        end
        else if (busy_reg)
        begin
            sh_next = {sh_reg[SH_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[R_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[R_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N_IT - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            // Round to nearest: bump when the remainder exceeds the root
            if (rem_reg > RM_W'(root_reg))
                root_out_next = (R_W + 1)'(root_reg) + 1'b1;
            else
                root_out_next = (R_W + 1)'(root_reg);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers need no reset
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        sh_reg       <= sh_next;
        root_out_reg <= root_out_next;
    end

    assign done     = done_reg;
    assign root_out = root_out_reg;

endmodule

/* sv/polyline_length_and_area.sv */
`timescale 1ns / 1ps
// polyline_length_and_area: path length and shoelace area of one curve.
// Depends on plen_pkg, plen_mul and plen_isqrt.
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------------------
//  point   | point_valid / point_stall  | point_x, point_y, curve_closed, last_vertex
//  result  | result_valid / result_stall| path_length_q8, area_halves, vertex_count,
//          |                            | too_many
//
// A vertex that adds a segment steps through S_SQ_X, S_SQ_Y, S_TERM, S_START,
// S_WAIT and S_NEXT; in S_WAIT the bit-serial square root works out its
// (2*COORD_BITS+2)/2 + LENGTH_FRAC_BITS root bits. Three products share one
// multiplier, one per cycle. A closed curve's last vertex also runs the closing segment,
// then posts. The first vertex and dropped vertices go straight to S_NEXT.
// point_stall is high while a request is in work; a posted result waits in the
// output register. Reset is asynchronous and needs no clearing pass.

module polyline_length_and_area #(
    parameter int MAX_POINTS       = plen_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS       = plen_pkg::COORD_BITS_DEF,
    parameter int LENGTH_FRAC_BITS = plen_pkg::LENGTH_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              point_valid,
    output logic                              point_stall,
    input  logic signed [COORD_BITS-1:0]      point_x,
    input  logic signed [COORD_BITS-1:0]      point_y,
    input  logic                              curve_closed,
    input  logic                              last_vertex,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [plen_pkg::LEN_W-1:0]        path_length_q8,
    output logic [plen_pkg::AREA_OUT_W-1:0]   area_halves,
    output logic [plen_pkg::COUNT_W-1:0]      vertex_count,
    output logic                              too_many
);

    localparam int D_W    = COORD_BITS + 1;
    localparam int P_W    = 2 * D_W;
    localparam int D2_W   = 2 * COORD_BITS + 1;
    localparam int N_IT   = (D2_W + 1) / 2 + LENGTH_FRAC_BITS;
    localparam int SQ_W   = N_IT + 1;
    localparam int LS_W   = ((plen_pkg::LEN_W > SQ_W) ? plen_pkg::LEN_W : SQ_W) + 1;
    localparam int AW     = ((plen_pkg::AREA_SUM_W > P_W) ? plen_pkg::AREA_SUM_W : P_W) + 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int AS_W   = plen_pkg::AREA_SUM_W;

    localparam logic signed [AW-1:0] AREA_HI = AW'(plen_pkg::AREA_MAX);
    localparam logic signed [AW-1:0] AREA_LO = -AREA_HI;

    plen_pkg::state_t state_reg, state_next;

    logic signed [COORD_BITS-1:0] first_x_reg, first_x_next;
    logic signed [COORD_BITS-1:0] first_y_reg, first_y_next;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_x_next;
    logic signed [COORD_BITS-1:0] prev_y_reg, prev_y_next;
    logic [plen_pkg::LEN_W-1:0]   length_sum_reg, length_sum_next;
    logic signed [AS_W-1:0]       area_sum_reg, area_sum_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         overflow_reg, overflow_next;
    logic                         last_reg, last_next;
    logic                         closed_reg, closed_next;
    logic                         closing_reg, closing_next;

    logic signed [D_W-1:0]        dx_reg, dx_next;
    logic signed [D_W-1:0]        dy_reg, dy_next;
    logic signed [D_W-1:0]        sy_reg, sy_next;
    logic [D2_W-1:0]              d2_reg, d2_next;

    logic                           result_valid_reg, result_valid_next;
    logic [plen_pkg::LEN_W-1:0]     length_out_reg, length_out_next;
    logic [plen_pkg::AREA_OUT_W-1:0] area_out_reg, area_out_next;
    logic [plen_pkg::COUNT_W-1:0]   count_out_reg, count_out_next;
    logic                           too_many_reg, too_many_next;

    logic signed [D_W-1:0]  mul_a, mul_b;
    logic signed [P_W-1:0]  mul_prod;
    logic                   isq_start;
    logic                   isq_done;
    logic [SQ_W-1:0]        isq_len;

    logic [LS_W-1:0]        len_wide;
    logic signed [AW-1:0]   area_wide;
    logic signed [AS_W-1:0] area_abs;

    // Shared multiplier: dx*dx, dy*dy, then dx*(y_b + y_a)
    plen_mul #(
        .A_W (D_W)
    ) u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    // Shared bit-serial square root of the segment length
    plen_isqrt #(
        .RAD_W     (D2_W),
        .FRAC_BITS (LENGTH_FRAC_BITS)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (isq_start),
        .radicand (d2_reg),
        .done     (isq_done),
        .root_out (isq_len)
    );

    // Select multiplier operands by sequencer step
    always_comb
    begin
        unique case (state_reg)
            plen_pkg::S_SQ_Y:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            plen_pkg::S_TERM:
            begin
                mul_a = dx_reg;
                mul_b = sy_reg;
            end
            default:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
        endcase
    end

    // Wide sums for saturation, and absolute area
    always_comb
    begin
        len_wide  = LS_W'(length_sum_reg) + LS_W'(isq_len);
        area_wide = AW'(area_sum_reg) + AW'(mul_prod);
        area_abs  = (area_sum_reg < 0) ? -area_sum_reg : area_sum_reg;
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next        = state_reg;
        first_x_next      = first_x_reg;
        first_y_next      = first_y_reg;
        prev_x_next       = prev_x_reg;
        prev_y_next       = prev_y_reg;
        length_sum_next   = length_sum_reg;
        area_sum_next     = area_sum_reg;
        count_next        = count_reg;
        overflow_next     = overflow_reg;
        last_next         = last_reg;
        closed_next       = closed_reg;
        closing_next      = closing_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        sy_next           = sy_reg;
        d2_next           = d2_reg;
        isq_start         = 1'b0;
        result_valid_next = result_valid_reg & result_stall;
        length_out_next   = length_out_reg;
        area_out_next     = area_out_reg;
        count_out_next    = count_out_reg;
        too_many_next     = too_many_reg;

        unique case (state_reg)
            plen_pkg::S_IDLE:
            begin
                if (point_valid)
                begin
                    last_next    = last_vertex;
                    closed_next  = curve_closed;
                    closing_next = 1'b0;
                    if (count_reg == '0)
                    begin
                        first_x_next = point_x;
                        first_y_next = point_y;
                        prev_x_next  = point_x;
                        prev_y_next  = point_y;
                        count_next   = CNT_W'(1);
                        state_next   = plen_pkg::S_NEXT;
                    end
                    else if (count_reg != CNT_W'(MAX_POINTS))
                    begin
                        dx_next     = D_W'(point_x) - D_W'(prev_x_reg);
                        dy_next     = D_W'(point_y) - D_W'(prev_y_reg);
                        sy_next     = D_W'(point_y) + D_W'(prev_y_reg);
                        prev_x_next = point_x;
                        prev_y_next = point_y;
                        count_next  = count_reg + 1'b1;
                        state_next  = plen_pkg::S_SQ_X;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                        state_next    = plen_pkg::S_NEXT;
                    end
                end
            end
            plen_pkg::S_SQ_X:
            begin
                state_next = plen_pkg::S_SQ_Y;
            end
            plen_pkg::S_SQ_Y:
            begin
                d2_next    = D2_W'($unsigned(mul_prod));
                state_next = plen_pkg::S_TERM;
            end
            plen_pkg::S_TERM:
            begin
                d2_next    = d2_reg + D2_W'($unsigned(mul_prod));
                state_next = plen_pkg::S_START;
            end
            plen_pkg::S_START:
            begin
                // Kick off the root and fold in the trapezoid term
                isq_start = 1'b1;
                if (area_wide > AREA_HI)
                    area_sum_next = AS_W'(AREA_HI);
                else if (area_wide < AREA_LO)
                    area_sum_next = AS_W'(AREA_LO);
                else
                    area_sum_next = AS_W'(area_wide);
                state_next = plen_pkg::S_WAIT;
            end
            plen_pkg::S_WAIT:
            begin
                if (isq_done)
                begin
                    if (len_wide > LS_W'(plen_pkg::LEN_MAX))
                        length_sum_next = plen_pkg::LEN_MAX;
                    else
                        length_sum_next = plen_pkg::LEN_W'(len_wide);
                    state_next = plen_pkg::S_NEXT;
                end
            end
            plen_pkg::S_NEXT:
            begin
                if (last_reg && closed_reg && !closing_reg)
                begin
                    // Closing segment from the last kept vertex back to the first
                    dx_next      = D_W'(first_x_reg) - D_W'(prev_x_reg);
                    dy_next      = D_W'(first_y_reg) - D_W'(prev_y_reg);
                    sy_next      = D_W'(first_y_reg) + D_W'(prev_y_reg);
                    closing_next = 1'b1;
                    state_next   = plen_pkg::S_SQ_X;
                end
                else if (last_reg)
                    state_next = plen_pkg::S_DONE;
                else
                    state_next = plen_pkg::S_IDLE;
            end
            plen_pkg::S_DONE:
            begin
                // Post the result once the output register is free, then clear
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    length_out_next   = length_sum_reg;
                    area_out_next     = closed_reg ? plen_pkg::AREA_OUT_W'(area_abs) : '0;
                    count_out_next    = plen_pkg::COUNT_W'(count_reg);
                    too_many_next     = overflow_reg;
                    first_x_next      = '0;
                    first_y_next      = '0;
                    prev_x_next       = '0;
                    prev_y_next       = '0;
                    length_sum_next   = '0;
                    area_sum_next     = '0;
                    count_next        = '0;
                    overflow_next     = 1'b0;
                    state_next        = plen_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = plen_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= plen_pkg::S_IDLE;
            first_x_reg      <= '0;
            first_y_reg      <= '0;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            length_sum_reg   <= '0;
            area_sum_reg     <= '0;
            count_reg        <= '0;
            overflow_reg     <= 1'b0;
            last_reg         <= 1'b0;
            closed_reg       <= 1'b0;
            closing_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_x_reg      <= first_x_next;
            first_y_reg      <= first_y_next;
            prev_x_reg       <= prev_x_next;
            prev_y_reg       <= prev_y_next;
            length_sum_reg   <= length_sum_next;
            area_sum_reg     <= area_sum_next;
            count_reg        <= count_next;
            overflow_reg     <= overflow_next;
            last_reg         <= last_next;
            closed_reg       <= closed_next;
            closing_reg      <= closing_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Segment operands and result payload hold without reset
    always_ff @(posedge clk)
    begin
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        sy_reg         <= sy_next;
        d2_reg         <= d2_next;
        length_out_reg <= length_out_next;
        area_out_reg   <= area_out_next;
        count_out_reg  <= count_out_next;
        too_many_reg   <= too_many_next;
    end

    assign point_stall    = (state_reg != plen_pkg::S_IDLE);
    assign result_valid   = result_valid_reg;
    assign path_length_q8 = length_out_reg;
    assign area_halves    = area_out_reg;
    assign vertex_count   = count_out_reg;
    assign too_many       = too_many_reg;

    // The vertex count never runs past the limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("vertex count above limit");

    // The area sum stays inside its saturation range
    a_area_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (AW'(area_sum_reg) <= AREA_HI) && (AW'(area_sum_reg) >= AREA_LO))
        else $error("area sum outside saturation range");

    // A root finishes only while the sequencer waits for it
    a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
        isq_done |-> (state_reg == plen_pkg::S_WAIT))
        else $error("root finished outside the wait step");

    // A new result appears only after the posting step
    a_post: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == plen_pkg::S_DONE))
        else $error("result posted outside the posting step");

    // After posting, the curve state is cleared
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plen_pkg::S_DONE && (!result_valid_reg || !result_stall))
        |=> (count_reg == '0 && length_sum_reg == '0 && !overflow_reg))
        else $error("curve state not cleared after posting");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking testbench for polyline_length_and_area, path length and shoelace area.
// Depends on plen_pkg and the polyline_length_and_area RTL; stimulus, prediction and checks
// live here.

module tb;

    localparam int CW           = plen_pkg::COORD_BITS_DEF;
    localparam int FRAC_BITS    = plen_pkg::LENGTH_FRAC_BITS_DEF;
    localparam int VERTEX_LIMIT = plen_pkg::MAX_POINTS_DEF;
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_POINTS = 840;
    localparam int MAX_LOGGED   = 100;

    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

    localparam logic OPEN   = 1'b0;
    localparam logic CLOSED = 1'b1;
    localparam logic MID    = 1'b0;
    localparam logic LAST   = 1'b1;

    localparam longint unsigned LEN_LIMIT  = (64'd1 << plen_pkg::LEN_W) - 1;
    localparam longint          AREA_LIMIT = (64'sd1 << plen_pkg::AREA_OUT_W) - 1;

    typedef struct {
        logic [plen_pkg::LEN_W-1:0]      length_q8;
        logic [plen_pkg::AREA_OUT_W-1:0] area;
        logic [plen_pkg::COUNT_W-1:0]    count;
        logic                            dropped;
    } curve_summary_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                point_valid = 1'b0;
    logic                                point_stall;
    logic signed [CW-1:0]                point_x = '0;
    logic signed [CW-1:0]                point_y = '0;
    logic                                curve_closed = 1'b0;
    logic                                last_vertex = 1'b0;
    logic                                result_valid;
    logic                                result_stall = 1'b0;
    logic [plen_pkg::LEN_W-1:0]          path_length_q8;
    logic [plen_pkg::AREA_OUT_W-1:0]     area_halves;
    logic [plen_pkg::COUNT_W-1:0]        vertex_count;
    logic                                too_many;

    // Running state of the curve being predicted
    longint          acc_first_x, acc_first_y, acc_prev_x, acc_prev_y;
    longint unsigned acc_length;
    longint          acc_area;
    int              acc_count;
    logic            acc_dropped;

    curve_summary_t  expected_curves[$];
    curve_summary_t  oldest;
    int              mismatches = 0;
    int              points_sent = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              hold_request = 0;
    int              hold_left = 0;
    int              quiet_cycles = 0;

    polyline_length_and_area uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .point_valid    (point_valid),
        .point_stall    (point_stall),
        .point_x        (point_x),
        .point_y        (point_y),
        .curve_closed   (curve_closed),
        .last_vertex    (last_vertex),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .path_length_q8 (path_length_q8),
        .area_halves    (area_halves),
        .vertex_count   (vertex_count),
        .too_many       (too_many)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Round sqrt(dist_sq) to FRAC_BITS fraction bits: integer root of the scaled value,
    // bumped up when the exact root reaches lo + 1/2, i.e. the remainder exceeds lo
    function automatic longint unsigned seg_length_q8(input longint unsigned dist_sq);
        longint unsigned scaled, lo, hi, mid;
        scaled = dist_sq << (2 * FRAC_BITS);
        lo = 0;
        hi = 64'd1 << 26;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= scaled)
                lo = mid;
            else
                hi = mid;
        end
        return (scaled - lo * lo > lo) ? lo + 1 : lo;
    endfunction

    task automatic clear_curve();
        acc_first_x = 0;
        acc_first_y = 0;
        acc_prev_x  = 0;
        acc_prev_y  = 0;
        acc_length  = 0;
        acc_area    = 0;
        acc_count   = 0;
        acc_dropped = 1'b0;
    endtask

    // Add one edge's length and trapezoid term, saturating both sums
    task automatic add_edge(input longint ax, input longint ay, input longint bx,
                            input longint by);
        longint          dx, dy;
        longint unsigned len;
        dx = bx - ax;
        dy = by - ay;
        len = seg_length_q8(dx * dx + dy * dy);
        acc_length = (len > LEN_LIMIT - acc_length) ? LEN_LIMIT : acc_length + len;
        acc_area = acc_area + dx * (by + ay);
        if (acc_area > AREA_LIMIT)
            acc_area = AREA_LIMIT;
        else if (acc_area < -AREA_LIMIT)
            acc_area = -AREA_LIMIT;
    endtask

    // Fold one accepted vertex into the curve; queue the summary on the last one
    task automatic predict_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                                  input logic closed, input logic last);
        longint         vx, vy, magnitude;
        curve_summary_t summary;
        vx = x;
        vy = y;
        if (acc_count == 0)
        begin
            acc_first_x = vx;
            acc_first_y = vy;
            acc_prev_x  = vx;
            acc_prev_y  = vy;
            acc_count   = 1;
        end
        else if (acc_count < VERTEX_LIMIT)
        begin
            add_edge(acc_prev_x, acc_prev_y, vx, vy);
            acc_prev_x = vx;
            acc_prev_y = vy;
            acc_count++;
        end
        else
            acc_dropped = 1'b1;

        if (last)
        begin
            if (closed)
                add_edge(acc_prev_x, acc_prev_y, acc_first_x, acc_first_y);
            magnitude = (acc_area < 0) ? -acc_area : acc_area;
            summary.length_q8 = acc_length[plen_pkg::LEN_W-1:0];
            summary.area      = closed ? magnitude[plen_pkg::AREA_OUT_W-1:0] : '0;
            summary.count     = acc_count[plen_pkg::COUNT_W-1:0];
            summary.dropped   = acc_dropped;
            expected_curves.push_back(summary);
            clear_curve();
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking, receiver stalls and watchdog
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        // keep the log short when a fault repeats
        if (mismatches < MAX_LOGGED)
            $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Compare each accepted result against the oldest queued summary
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (expected_curves.size() == 0)
                report_mismatch("result with none outstanding", 0, 0);
            else
            begin
                oldest = expected_curves.pop_front();
                if (path_length_q8 !== oldest.length_q8)
                    report_mismatch("path_length_q8", path_length_q8, oldest.length_q8);
                if (area_halves !== oldest.area)
                    report_mismatch("area_halves", area_halves, oldest.area);
                if (vertex_count !== oldest.count)
                    report_mismatch("vertex_count", vertex_count, oldest.count);
                if (too_many !== oldest.dropped)
                    report_mismatch("too_many", too_many, oldest.dropped);
            end
        end
    end

    // Drive result_stall: a requested hold-off first, random stalls otherwise
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // End the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((point_valid === 1'b1 && point_stall === 1'b0) ||
            (result_valid === 1'b1 && result_stall === 1'b0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (entered and left at a falling edge)
    // ------------------------------------------------------------------

    // Offer one request and hold it until accepted
    task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                              input logic closed, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            point_valid <= 1'b0;
            @(negedge clk);
        end
        point_valid  <= 1'b1;
        point_x      <= x;
        point_y      <= y;
        curve_closed <= closed;
        last_vertex  <= last;
        do
            @(posedge clk);
        while (point_stall !== 1'b0);
        predict_vertex(x, y, closed, last);
        points_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every queued summary has come back
    task automatic drain_results();
        point_valid <= 1'b0;
        while (expected_curves.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return C_MIN;
            1:       return C_MAX;
            2, 3:    return CW'($urandom_range(0, 16) - 8);
            default: return CW'($urandom());
        endcase
    endfunction

    // Mostly short curves, now and then a longer one
    function automatic int rand_curve_len();
        case ($urandom_range(0, 9))
            0:       return 1;
            8:       return $urandom_range(9, 30);
            9:       return $urandom_range(31, 80);
            default: return $urandom_range(2, 8);
        endcase
    endfunction

    // Send one curve of random vertices; curve_closed toggles freely before the last one
    task automatic send_curve(input int n, input logic closed);
        int k;
        for (k = 0; k < n; k++)
        begin
            if (k == n - 1)
                send_point(rand_coord(), rand_coord(), closed, LAST);
            else
                send_point(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)), MID);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes, single-vertex, open and closed curves, both windings, zero-length edges
    task automatic test_directed();
        send_idle_pct = 31;
        recv_idle_pct = 59;
        // single vertex, open and closed
        send_point(C_MIN, C_MAX, OPEN, LAST);
        send_point(C_MAX, C_MIN, CLOSED, LAST);
        // edge from the origin of whole-number length
        send_point(0, 0, OPEN, MID);
        send_point(3, 4, OPEN, LAST);
        // full-range square, closed then open
        send_point(C_MIN, C_MIN, OPEN, MID);
        send_point(C_MAX, C_MIN, OPEN, MID);
        send_point(C_MAX, C_MAX, OPEN, MID);
        send_point(C_MIN, C_MAX, CLOSED, LAST);
        send_point(C_MIN, C_MIN, CLOSED, MID);
        send_point(C_MAX, C_MIN, OPEN, MID);
        send_point(C_MAX, C_MAX, CLOSED, MID);
        send_point(C_MIN, C_MAX, OPEN, LAST);
        // longest diagonal there and back
        send_point(C_MIN, C_MIN, OPEN, MID);
        send_point(C_MAX, C_MAX, CLOSED, LAST);
        // repeated vertex gives a zero-length edge
        send_point(5, -5, CLOSED, MID);
        send_point(5, -5, OPEN, LAST);
        // triangle with the opposite winding
        send_point(0, 0, OPEN, MID);
        send_point(0, 100, OPEN, MID);
        send_point(100, 0, CLOSED, LAST);
        // edge across the origin
        send_point(-1, -1, OPEN, MID);
        send_point(1, 1, CLOSED, LAST);
    endtask

    // Run a closed curve past the vertex limit; its last two vertices are dropped, so the
    // closing edge starts at the last kept vertex
    task automatic test_vertex_limit();
        send_idle_pct = 0;
        recv_idle_pct = 20;
        send_curve(VERTEX_LIMIT + 2, CLOSED);
    endtask

    // Hold the result side off while requests keep coming, then pause until all drain
    task automatic test_backpressure();
        int k;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = HOLD_CYCLES;
        for (k = 0; k < 8; k++)
            send_curve(2, 1'($urandom_range(0, 1)));
        drain_results();
        @(negedge clk);
        send_curve(3, CLOSED);
        send_curve(1, OPEN);
    endtask

    // Random curves under three idling patterns
    task automatic test_random();
        int phase, stop_at;
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 31;
                    recv_idle_pct = 59;
                end
                1:
                begin
                    send_idle_pct = 59;
                    recv_idle_pct = 31;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            stop_at = points_sent + RANDOM_POINTS / 3;
            while (points_sent < stop_at)
                send_curve(rand_curve_len(), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        clear_curve();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_vertex_limit();
        test_backpressure();
        test_random();

        // Let the last results out, then give the block time to settle
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_curves.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
sv/plen_pkg.sv
sv/plen_mul.sv
sv/plen_isqrt.sv
sv/polyline_length_and_area.sv
tb/sv/tb.sv
